FILE: src/ccmm_pkg.sv
// Shared types and constants for the cartridge memory mapper.
package ccmm_pkg;

   localparam int MAIN_RAM_DEPTH = 16384;
   localparam int WORK_RAM_DEPTH = 2048;
   localparam int ROM_DEPTH      = 8192;

   localparam int MAIN_AW = $clog2(MAIN_RAM_DEPTH);
   localparam int WORK_AW = $clog2(WORK_RAM_DEPTH);
   localparam int ROM_AW  = $clog2(ROM_DEPTH);

   // Main RAM, ROM and work RAM share one array, stacked in that order.
   localparam int MAIN_BASE = 0;
   localparam int ROM_BASE  = MAIN_BASE + MAIN_RAM_DEPTH;
   localparam int WORK_BASE = ROM_BASE + ROM_DEPTH;
   localparam int MEM_DEPTH = WORK_BASE + WORK_RAM_DEPTH;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   localparam int OP_W   = 3;
   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;

   localparam logic [ADDR_W-1:0] PAGE1_START = 16'h4000;
   localparam logic [ADDR_W-1:0] WORK_START  = 16'h6000;
   localparam logic [ADDR_W-1:0] MAP_END     = 16'h8000;

   localparam logic [DATA_W-1:0] IDLE_BYTE  = 8'hFF;
   localparam logic [DATA_W-1:0] CTRL_RESET = 8'hFF;

   localparam int CTRL_COPY_LED_BIT  = 0;
   localparam int CTRL_PAUSE_LED_BIT = 1;
   localparam int CTRL_PROTECT_BIT   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_MEM_READ  = 3'd0,
      OP_MEM_WRITE = 3'd1,
      OP_IO_READ   = 3'd2,
      OP_IO_WRITE  = 3'd3,
      OP_ROM_LOAD  = 3'd4
   } op_type;

   // Decoded access for one word.
   typedef struct packed {
      logic              mem_en;
      logic              mem_we;
      logic              rd_mem;
      logic [MEM_AW-1:0] mem_addr;
      logic [DATA_W-1:0] imm_data;
      logic              ctrl_we;
   } access_type;

   typedef struct packed {
      logic copy_led_on;
      logic pause_led_on;
      logic page0_read_only;
   } flags_type;

endpackage

FILE: src/ccmm_ifs.sv
// Handshake channels of the cartridge memory mapper.
interface ccmm_req_if import ccmm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;
   logic              copy_pressed;
   logic              pause_pressed;

   modport source (output valid, operation, address, write_data, copy_pressed,
                   pause_pressed, input ready);
   modport sink (input valid, operation, address, write_data, copy_pressed,
                 pause_pressed, output ready);
endinterface

interface ccmm_rsp_if import ccmm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              copy_led_on;
   logic              pause_led_on;
   logic              page0_read_only;

   modport source (output valid, read_data, copy_led_on, pause_led_on,
                   page0_read_only, input ready);
   modport sink (input valid, read_data, copy_led_on, pause_led_on,
                 page0_read_only, output ready);
endinterface

interface ccmm_csr_if import ccmm_pkg::*; ();
   logic valid;
   logic ready;
   logic cartridge_mode;

   modport source (output valid, cartridge_mode, input ready);
   modport sink (input valid, cartridge_mode, output ready);
endinterface

FILE: src/ccmm_ram.sv
// Single-port synchronous RAM with registered read data.
module ccmm_ram #(
   parameter int  DEPTH  = 1024,
   parameter int  WIDTH  = 8,
   localparam int AW     = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[addr] <= wdata;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (en && !we) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/ccmm_decode.sv
// Address and operation decoder: maps one bus word onto the shared memory.
module ccmm_decode import ccmm_pkg::*; (
   input  logic [OP_W-1:0]   operation,
   input  logic [ADDR_W-1:0] address,
   input  logic              copy_pressed,
   input  logic              pause_pressed,
   input  logic              cartridge_mode,
   input  logic [DATA_W-1:0] control,
   output access_type        acc
);

   logic in_low;
   logic in_rom;
   logic in_work;
   logic in_high;

   logic [MEM_AW-1:0] main_low_addr;
   logic [MEM_AW-1:0] rom_addr;
   logic [MEM_AW-1:0] work_addr;

   always_comb begin
      in_low  = address < PAGE1_START;
      in_rom  = !in_low && (address < WORK_START);
      in_work = (address >= WORK_START) && (address < MAP_END);
      in_high = (address >= PAGE1_START) && (address < MAP_END);

      main_low_addr = MEM_AW'(MAIN_BASE) + MEM_AW'(address[MAIN_AW-1:0]);
      rom_addr      = MEM_AW'(ROM_BASE) + MEM_AW'(address[ROM_AW-1:0]);
      work_addr     = MEM_AW'(WORK_BASE) + MEM_AW'(address[WORK_AW-1:0]);

      acc          = '0;
      acc.imm_data = IDLE_BYTE;
      acc.mem_addr = main_low_addr;

      case (op_type'(operation))
         OP_MEM_READ: begin
            if (!cartridge_mode) begin
               if (in_low) begin
                  acc.mem_en = 1'b1;
                  acc.rd_mem = 1'b1;
               end else if (in_rom) begin
                  acc.mem_en   = 1'b1;
                  acc.rd_mem   = 1'b1;
                  acc.mem_addr = rom_addr;
               end else if (in_work) begin
                  acc.mem_en   = 1'b1;
                  acc.rd_mem   = 1'b1;
                  acc.mem_addr = work_addr;
               end
            end else if (in_high) begin
               acc.mem_en = 1'b1;
               acc.rd_mem = 1'b1;
            end
         end
         OP_MEM_WRITE: begin
            if (!cartridge_mode) begin
               if (in_low) begin
                  acc.mem_en = !control[CTRL_PROTECT_BIT];
                  acc.mem_we = !control[CTRL_PROTECT_BIT];
               end else if (in_work) begin
                  acc.mem_en   = 1'b1;
                  acc.mem_we   = 1'b1;
                  acc.mem_addr = work_addr;
               end
            end else if (in_high) begin
               acc.mem_en = 1'b1;
               acc.mem_we = 1'b1;
            end
         end
         OP_IO_READ: begin
            // Buttons read active low.
            acc.imm_data = {IDLE_BYTE[DATA_W-1:2], !pause_pressed, !copy_pressed};
         end
         OP_IO_WRITE: begin
            acc.ctrl_we = 1'b1;
         end
         OP_ROM_LOAD: begin
            acc.mem_en   = 1'b1;
            acc.mem_we   = 1'b1;
            acc.mem_addr = rom_addr;
         end
         default: begin
            acc.mem_en = 1'b0;
         end
      endcase
   end

endmodule

FILE: src/copy_cartridge_memory_mapper_unit.sv
// Top level of the cartridge memory mapper: control byte, shared memory, result path.
// The mapper takes one bus word per cycle unless stalled and returns exactly one
// result word for each, in order. Main RAM (16 KB), ROM (8 KB) and work RAM (2 KB)
// live in one single-port synchronous memory; each word does at most one access.
// A result passes through the memory's registered read and then the output
// register after its request is accepted. With rsp ready held high the sustained
// rate is one word per cycle; a stalled result blocks new requests only once
// both the read stage and the output register are full.
// RAM and ROM contents are undefined until written or loaded; there is no
// clearing pass after reset. Write cartridge_mode only while the mapper is idle.
module copy_cartridge_memory_mapper_unit import ccmm_pkg::*; (
   input logic        clock,
   input logic        reset,
   ccmm_req_if.sink   req_bus,
   ccmm_rsp_if.source rsp_bus,
   ccmm_csr_if.sink   csr_bus
);

   // Configuration and control state.
   logic              mode_ff;
   logic [DATA_W-1:0] control_ff;
   logic [DATA_W-1:0] control_in;

   // Read stage: the word whose memory read is in flight.
   logic              s1_valid_ff;
   logic              s1_rd_mem_ff;
   logic [DATA_W-1:0] s1_imm_ff;
   flags_type         s1_flags_ff;
   flags_type         flags_in;

   // Output register.
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_data_ff;
   flags_type         out_flags_ff;

   access_type        acc;
   logic              req_fire;
   logic              s1_advance;
   logic              mem_en;
   logic [DATA_W-1:0] mem_rdata;

   ccmm_decode u_decode (
      .operation      (req_bus.operation),
      .address        (req_bus.address),
      .copy_pressed   (req_bus.copy_pressed),
      .pause_pressed  (req_bus.pause_pressed),
      .cartridge_mode (mode_ff),
      .control        (control_ff),
      .acc            (acc)
   );

   // Advance the read stage whenever the output register is free or drains.
   assign s1_advance    = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   // Take nothing while reset is held.
   assign req_bus.ready = !reset && (!s1_valid_ff || s1_advance);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign mem_en        = req_fire && acc.mem_en;

   ccmm_ram #(
      .DEPTH (MEM_DEPTH),
      .WIDTH (DATA_W)
   ) u_mem (
      .clock (clock),
      .en    (mem_en),
      .we    (acc.mem_we),
      .addr  (acc.mem_addr),
      .wdata (req_bus.write_data),
      .rdata (mem_rdata)
   );

   // Flags show the control byte after this word's operation.
   always_comb begin
      control_in = (req_fire && acc.ctrl_we) ? req_bus.write_data : control_ff;
      flags_in.copy_led_on     = !control_in[CTRL_COPY_LED_BIT];
      flags_in.pause_led_on    = !control_in[CTRL_PAUSE_LED_BIT];
      flags_in.page0_read_only = control_in[CTRL_PROTECT_BIT];
   end

   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         control_ff   <= CTRL_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            mode_ff <= csr_bus.cartridge_mode;
         end
         control_ff <= control_in;
         // Hold the read stage while the output register is stalled.
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_rd_mem_ff <= acc.rd_mem;
         s1_imm_ff    <= acc.imm_data;
         s1_flags_ff  <= flags_in;
      end
      // Memory read data holds while stalled since no new read is issued.
      if (s1_advance) begin
         out_data_ff  <= s1_rd_mem_ff ? mem_rdata : s1_imm_ff;
         out_flags_ff <= s1_flags_ff;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.read_data       = out_data_ff;
   assign rsp_bus.copy_led_on     = out_flags_ff.copy_led_on;
   assign rsp_bus.pause_led_on    = out_flags_ff.pause_led_on;
   assign rsp_bus.page0_read_only = out_flags_ff.page0_read_only;

endmodule
